// File: rtl/stp_pkg.sv
// Package for the ramped stepper step generator.
// Holds widths, register reset values, codes and the structs used by the csr, core and top-level files.
// Depends on nothing.
package stp_pkg;

   localparam int POS_W       = 32;
   localparam int SPEED_W     = 18;
   localparam int GOAL_VEL_W  = 19;
   localparam int ACCEL_W     = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ACC_W       = FRAC_BITS + 3;
   localparam int STEP_W      = 3;
   localparam int MAX_STEPS   = 4;
   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 1;

   localparam logic [ACCEL_W-1:0] ACCEL_RESET   = 16'd66;
   localparam logic [SPEED_W-1:0] MAX_VEL_RESET = 18'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_RATE  = 1'b0,
      CSR_SPEED_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_MOVE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [ACCEL_W-1:0] accel_rate;
      logic [SPEED_W-1:0] speed_limit;
   } cfg_type;

   typedef struct packed {
      logic [STEP_W-1:0]       step_count;
      logic                    direction;
      logic signed [POS_W-1:0] position;
      logic [SPEED_W-1:0]      velocity;
      logic                    at_target;
   } rsp_data_type;

endpackage

// File: rtl/stp_if.sv
// Channel interfaces for the step generator: request, response and register write.
// Depends on stp_pkg for the field widths.
interface stp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic signed [stp_pkg::POS_W-1:0]     goal_position;
   logic signed [stp_pkg::GOAL_VEL_W-1:0] goal_velocity;

   modport source (output valid, output req_type, output goal_position,
                   output goal_velocity, input ready);
   modport sink (input valid, input req_type, input goal_position,
                 input goal_velocity, output ready);
endinterface

interface stp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [stp_pkg::STEP_W-1:0]       step_count;
   logic                             direction;
   logic signed [stp_pkg::POS_W-1:0] position;
   logic [stp_pkg::SPEED_W-1:0]      velocity;
   logic                             at_target;

   modport source (output valid, output step_count, output direction, output position,
                   output velocity, output at_target, input ready);
   modport sink (input valid, input step_count, input direction, input position,
                 input velocity, input at_target, output ready);
endinterface

interface stp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [stp_pkg::CSR_INDEX_W-1:0]   index;
   logic [stp_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/stp_csr.sv
// Configuration registers of the step generator: acceleration rate and velocity ceiling.
// Depends on stp_pkg.
module stp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_valid,
   input  logic [stp_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [stp_pkg::CSR_DATA_W-1:0]    wr_data,
   output stp_pkg::cfg_type                  cfg
);

   stp_pkg::cfg_type cfg_ff;
   stp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (stp_pkg::csr_index_type'(wr_index))
            stp_pkg::CSR_ACCEL_RATE: begin
               cfg_in.accel_rate = wr_data[stp_pkg::ACCEL_W-1:0];
            end
            stp_pkg::CSR_SPEED_LIMIT: begin
               cfg_in.speed_limit = wr_data[stp_pkg::SPEED_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_rate  <= stp_pkg::ACCEL_RESET;
         cfg_ff.speed_limit <= stp_pkg::MAX_VEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/stp_core.sv
// Motion state of the step generator and its per-transaction update: speed ramp,
// phase accumulator and step count. Depends on stp_pkg.
module stp_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  req_type,
   input  logic signed [stp_pkg::POS_W-1:0]      goal_position,
   input  logic signed [stp_pkg::GOAL_VEL_W-1:0] goal_velocity,
   input  stp_pkg::cfg_type                      cfg,
   output stp_pkg::rsp_data_type                 result
);

   localparam int POS_W   = stp_pkg::POS_W;
   localparam int SPEED_W = stp_pkg::SPEED_W;
   localparam int ACC_W   = stp_pkg::ACC_W;
   localparam int STEP_W  = stp_pkg::STEP_W;
   localparam int FRAC    = stp_pkg::FRAC_BITS;

   logic signed [POS_W-1:0] cur_pos_ff, cur_pos_in;
   logic signed [POS_W-1:0] tgt_pos_ff, tgt_pos_in;
   logic [SPEED_W-1:0]      cur_speed_ff, cur_speed_in;
   logic [SPEED_W-1:0]      tgt_speed_ff, tgt_speed_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;

   logic [SPEED_W-1:0] goal_clamped;
   logic               up;
   logic [SPEED_W-1:0] speed_err;
   logic [SPEED_W-1:0] ramp_speed;
   logic [ACC_W:0]     acc_sum;
   logic [ACC_W-1:0]   acc_sat;
   logic [POS_W:0]     pos_gap;
   logic [STEP_W-1:0]  whole_raw;
   logic [STEP_W-1:0]  cap;
   logic [STEP_W-1:0]  whole;
   logic [POS_W-1:0]   pos_step;

   always_comb begin
      if (goal_velocity[stp_pkg::GOAL_VEL_W-1]) begin
         goal_clamped = '0;
      end else if (goal_velocity[SPEED_W-1:0] > cfg.speed_limit) begin
         goal_clamped = cfg.speed_limit;
      end else begin
         goal_clamped = goal_velocity[SPEED_W-1:0];
      end
   end

   always_comb begin
      up = tgt_pos_ff > cur_pos_ff;
      if (tgt_speed_ff > cur_speed_ff) begin
         speed_err  = tgt_speed_ff - cur_speed_ff;
         ramp_speed = (speed_err <= SPEED_W'(cfg.accel_rate)) ? tgt_speed_ff
                      : cur_speed_ff + SPEED_W'(cfg.accel_rate);
      end else begin
         speed_err  = cur_speed_ff - tgt_speed_ff;
         ramp_speed = (speed_err <= SPEED_W'(cfg.accel_rate)) ? tgt_speed_ff
                      : cur_speed_ff - SPEED_W'(cfg.accel_rate);
      end
      acc_sum = {1'b0, acc_ff} + (ACC_W+1)'(ramp_speed);
      acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      if (up) begin
         pos_gap = {tgt_pos_ff[POS_W-1], tgt_pos_ff} - {cur_pos_ff[POS_W-1], cur_pos_ff};
      end else begin
         pos_gap = {cur_pos_ff[POS_W-1], cur_pos_ff} - {tgt_pos_ff[POS_W-1], tgt_pos_ff};
      end
      whole_raw = acc_sat[ACC_W-1:FRAC];
      cap = (pos_gap < (POS_W+1)'(stp_pkg::MAX_STEPS)) ? pos_gap[STEP_W-1:0]
            : STEP_W'(stp_pkg::MAX_STEPS);
      whole = (whole_raw < cap) ? whole_raw : cap;
      pos_step = up ? cur_pos_ff + POS_W'(whole) : cur_pos_ff - POS_W'(whole);
   end

   always_comb begin
      cur_pos_in   = cur_pos_ff;
      tgt_pos_in   = tgt_pos_ff;
      cur_speed_in = cur_speed_ff;
      tgt_speed_in = tgt_speed_ff;
      acc_in       = acc_ff;
      result.step_count = '0;
      result.direction  = 1'b0;
      if (stp_pkg::req_kind_type'(req_type) == stp_pkg::REQ_MOVE) begin
         tgt_pos_in   = goal_position;
         tgt_speed_in = goal_clamped;
      end else if (cur_pos_ff == tgt_pos_ff) begin
         cur_speed_in = '0;
         tgt_speed_in = '0;
         acc_in       = '0;
      end else begin
         cur_speed_in = ramp_speed;
         acc_in       = acc_sat - (ACC_W'(whole) << FRAC);
         cur_pos_in   = pos_step;
         result.step_count = whole;
         result.direction  = up;
      end
      result.position  = cur_pos_in;
      result.velocity  = cur_speed_in;
      result.at_target = (cur_pos_in == tgt_pos_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pos_ff   <= '0;
         tgt_pos_ff   <= '0;
         cur_speed_ff <= '0;
         tgt_speed_ff <= '0;
         acc_ff       <= '0;
      end else if (accept) begin
         cur_pos_ff   <= cur_pos_in;
         tgt_pos_ff   <= tgt_pos_in;
         cur_speed_ff <= cur_speed_in;
         tgt_speed_ff <= tgt_speed_in;
         acc_ff       <= acc_in;
      end
   end

endmodule

// File: rtl/stepper_step_generator_ramped_unit.sv
// Ramped stepper step generator, top level. Depends on stp_pkg, the stp_*_if
// interfaces, stp_csr and stp_core.
// The response is registered and appears in the cycle after the request transaction.
// Throughput: one transaction per cycle while the response is taken; the response register frees as it is taken.
// Reset clears the motion state and the response valid flag and restores the
// configuration registers to their defaults.
module stepper_step_generator_ramped_unit (
   input  logic      clock,
   input  logic      reset,
   stp_req_if.sink   req_bus,
   stp_rsp_if.source rsp_bus,
   stp_csr_if.sink   csr_bus
);

   stp_pkg::cfg_type      cfg;
   stp_pkg::rsp_data_type result;
   stp_pkg::rsp_data_type rsp_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   stp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   stp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_bus.req_type),
      .goal_position (req_bus.goal_position),
      .goal_velocity (req_bus.goal_velocity),
      .cfg           (cfg),
      .result        (result)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.step_count = rsp_data_ff.step_count;
   assign rsp_bus.direction  = rsp_data_ff.direction;
   assign rsp_bus.position   = rsp_data_ff.position;
   assign rsp_bus.velocity   = rsp_data_ff.velocity;
   assign rsp_bus.at_target  = rsp_data_ff.at_target;

endmodule
